/* design/dpst_pkg.sv */
// package of types, codes and constants for the detector pair table
`timescale 1ns / 1ps
`default_nettype none

package dpst_pkg;

    // default table depth and bytes per pair element in main memory
    localparam int TABLE_ENTRIES_DEFAULT = 64;
    localparam int ELEM_BYTES            = 8;

    // port widths
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int DET_W   = 16;
    localparam int DCNT_W  = 13;
    localparam int ADDR_W  = 32;
    localparam int SLOT_W  = 6;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DETECTOR_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_BASE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOUNDARY_ID    = 2'd2;

    // configuration reset values
    localparam logic [DCNT_W-1:0] DETECTOR_COUNT_RST = 13'd4096;
    localparam logic [ADDR_W-1:0] TABLE_BASE_RST     = 32'd0;
    localparam logic [DET_W-1:0]  BOUNDARY_ID_RST    = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_ACCESS   = 2'd0,
        CMD_PREFETCH = 2'd1,
        CMD_FILL     = 2'd2,
        CMD_INVAL    = 2'd3
    } t_cmd;

    // controller to datapath
    typedef struct packed {
        logic take_in;
        logic addr1;
        logic addr2;
        logic addr3;
        logic scan_rd;
        logic sweep_wr;
        logic clear_wr;
        logic update;
        logic push;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic cnt_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* design/dpst_ctrl.sv */
// controller state machine of the detector pair table
`timescale 1ns / 1ps
`default_nettype none

module dpst_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  dpst_pkg::t_dp_status i_status,
    output dpst_pkg::t_dp_cmd    o_cmd
);
    import dpst_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_ADDR1  = 10'b00_0000_0100,
        S_ADDR2  = 10'b00_0000_1000,
        S_ADDR3  = 10'b00_0001_0000,
        S_SCAN   = 10'b00_0010_0000,
        S_DRAIN  = 10'b00_0100_0000,
        S_SWEEP  = 10'b00_1000_0000,
        S_UPDATE = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = S_ADDR1;
                end
            end
            S_ADDR1: begin
                o_cmd.addr1 = 1'b1;
                n_state     = (i_status.cmd == CMD_INVAL) ? S_SWEEP : S_ADDR2;
            end
            S_ADDR2: begin
                o_cmd.addr2 = 1'b1;
                n_state     = S_ADDR3;
            end
            S_ADDR3: begin
                o_cmd.addr3 = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* design/dpst_datapath.sv */
// datapath of the detector pair table: address map, entry memories, scan and result
`timescale 1ns / 1ps
`default_nettype none

module dpst_datapath #(
    parameter int TABLE_ENTRIES = dpst_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [dpst_pkg::IN_TDATA_W-1:0]    i_in_data,
    input  wire  [dpst_pkg::IN_TUSER_W-1:0]    i_in_user,
    input  wire                                i_cfg_we,
    input  wire  [dpst_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire  [dpst_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [dpst_pkg::OUT_TDATA_W-1:0]   o_out_data,
    input  dpst_pkg::t_dp_cmd                  i_cmd,
    output dpst_pkg::t_dp_status               o_status
);
    import dpst_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

    // configuration
    logic [DCNT_W-1:0] r_det_count;
    logic [ADDR_W-1:0] r_base;
    logic [DET_W-1:0]  r_boundary;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_count <= DETECTOR_COUNT_RST;
            r_base      <= TABLE_BASE_RST;
            r_boundary  <= BOUNDARY_ID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DETECTOR_COUNT: r_det_count <= i_cfg_data[DCNT_W-1:0];
                CFG_TABLE_BASE:     r_base      <= i_cfg_data[ADDR_W-1:0];
                CFG_BOUNDARY_ID:    r_boundary  <= i_cfg_data[DET_W-1:0];
                default: ;
            endcase
        end
    end

    // input word
    t_cmd             r_cmd;
    logic [DET_W-1:0] r_d1;
    logic [DET_W-1:0] r_d2;
    logic             r_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= CMD_ACCESS;
        end else if (i_cmd.take_in) begin
            r_cmd <= t_cmd'(i_in_user);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_d1   <= i_in_data[15:0];
            r_d2   <= i_in_data[31:16];
            r_mark <= i_in_data[32];
        end
    end

    // address map, three steps
    logic [DET_W-1:0]       lo_id;
    logic [DET_W-1:0]       hi_id;
    logic [ADDR_W-1:0]      bnd_slot;
    logic [ADDR_W-1:0]      r_b1;
    logic [ADDR_W-1:0]      r_b2;
    logic [ADDR_W-1:0]      r_prod;
    logic [ADDR_W-1:0]      r_diff;
    logic [ADDR_W-1:0]      r_addr;
    logic [ADDR_W+DCNT_W-1:0] prod_full;
    logic [ADDR_W-1:0]      offset;

    always_comb begin
        lo_id     = (r_d1 > r_d2) ? r_d2 : r_d1;
        hi_id     = (r_d1 > r_d2) ? r_d1 : r_d2;
        bnd_slot  = {{(ADDR_W-DCNT_W){1'b0}}, r_det_count} - 32'd1;
        prod_full = r_b1 * r_det_count;
        offset    = r_prod + r_diff;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.addr1) begin
            r_b1 <= (lo_id == r_boundary) ? bnd_slot : {16'd0, lo_id};
            r_b2 <= (hi_id == r_boundary) ? bnd_slot : {16'd0, hi_id};
        end
        if (i_cmd.addr2) begin
            r_prod <= prod_full[ADDR_W-1:0];
            r_diff <= r_b2 - r_b1 - 32'd1;
        end
        if (i_cmd.addr3) begin
            r_addr <= r_base + offset * 32'(ELEM_BYTES);
        end
    end

    // sweep counter shared by clearing, scan and invalidate
    logic [IW-1:0] r_cnt;
    logic          cnt_step;

    assign cnt_step = i_cmd.scan_rd | i_cmd.sweep_wr | i_cmd.clear_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (cnt_step) begin
            r_cnt <= (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;
        end
    end

    // entry memories
    logic [ADDR_W-1:0] mem_addr [TABLE_ENTRIES];
    logic              mem_ev   [TABLE_ENTRIES];
    logic              wa_en;
    logic [IW-1:0]     wa_idx;
    logic [ADDR_W-1:0] wa_data;
    logic              we_en;
    logic [IW-1:0]     we_idx;
    logic              we_data;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_rd_ev;
    logic              r_rd_vld;
    logic [IW-1:0]     r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (wa_en) begin
            mem_addr[wa_idx] <= wa_data;
        end
        if (i_cmd.scan_rd) begin
            r_rd_addr <= mem_addr[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_en) begin
            mem_ev[we_idx] <= we_data;
        end
        if (i_cmd.scan_rd) begin
            r_rd_ev <= mem_ev[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_rd_idx <= r_cnt;
        end
    end

    // scan results: first match, last evictable
    logic          r_found;
    logic [IW-1:0] r_hit_idx;
    logic          r_vict_vld;
    logic [IW-1:0] r_vict_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_vict_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.take_in) begin
                r_found    <= 1'b0;
                r_vict_vld <= 1'b0;
            end else if (r_rd_vld) begin
                if (!r_found && (r_rd_addr == r_addr)) begin
                    r_found <= 1'b1;
                end
                if (r_rd_ev) begin
                    r_vict_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld && !r_found && (r_rd_addr == r_addr)) begin
            r_hit_idx <= r_rd_idx;
        end
        if (r_rd_vld && r_rd_ev) begin
            r_vict_idx <= r_rd_idx;
        end
    end

    // update decode
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          res_hit;
    logic          res_filled;
    logic [IW-1:0] res_idx;

    always_comb begin
        wa_en      = 1'b0;
        wa_idx     = r_cnt;
        wa_data    = '0;
        we_en      = 1'b0;
        we_idx     = r_cnt;
        we_data    = 1'b1;
        n_count    = r_count;
        res_hit    = 1'b0;
        res_filled = 1'b0;
        res_idx    = '0;
        if (i_cmd.clear_wr) begin
            wa_en = 1'b1;
            we_en = 1'b1;
        end else if (i_cmd.sweep_wr) begin
            we_en = 1'b1;
        end else if (i_cmd.update) begin
            unique case (r_cmd)
                CMD_ACCESS: begin
                    if (r_found) begin
                        res_hit = 1'b1;
                        res_idx = r_hit_idx;
                        we_en   = r_mark;
                        we_idx  = r_hit_idx;
                        we_data = 1'b1;
                    end else if (r_vict_vld) begin
                        res_filled = 1'b1;
                        res_idx    = r_vict_idx;
                        wa_en      = 1'b1;
                        wa_idx     = r_vict_idx;
                        wa_data    = r_addr;
                        we_en      = 1'b1;
                        we_idx     = r_vict_idx;
                        we_data    = 1'b0;
                    end
                end
                CMD_PREFETCH: begin
                    if (r_found) begin
                        res_hit = 1'b1;
                        res_idx = r_hit_idx;
                        we_en   = 1'b1;
                        we_idx  = r_hit_idx;
                        we_data = 1'b0;
                    end else if (r_count < FULL_CNT) begin
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_FILL: begin
                    if (r_vict_vld) begin
                        res_filled = 1'b1;
                        res_idx    = r_vict_idx;
                        wa_en      = 1'b1;
                        wa_idx     = r_vict_idx;
                        wa_data    = r_addr;
                        we_en      = 1'b1;
                        we_idx     = r_vict_idx;
                        we_data    = 1'b0;
                    end
                end
                CMD_INVAL: begin
                    n_count = '0;
                end
                default: ;
            endcase
        end
    end

    // pending result, then output register
    logic              r_res_hit;
    logic              r_res_filled;
    logic              r_res_full;
    logic [IW-1:0]     r_res_idx;
    logic [ADDR_W-1:0] r_res_addr;
    logic [IW+SLOT_W-1:0] slot_ext;
    logic              r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.update) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_res_hit    <= res_hit;
            r_res_filled <= res_filled;
            r_res_full   <= (n_count >= FULL_CNT);
            r_res_idx    <= res_idx;
            r_res_addr   <= (r_cmd == CMD_INVAL) ? '0 : r_addr;
        end
    end

    // slot keeps its low six bits
    assign slot_ext = {{SLOT_W{1'b0}}, r_res_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_data <= {7'd0, r_res_full, r_res_filled, slot_ext[SLOT_W-1:0],
                           r_res_addr, r_res_hit};
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_out_data        = r_out_data;
    assign o_status.cmd      = r_cmd;
    assign o_status.cnt_last = (r_cnt == LAST_IDX);
    assign o_status.out_free = !r_out_vld || i_out_ready;

    // checks
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (!r_out_vld || i_out_ready))
        else $error("result pushed over an untaken word");

    a_rd_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(i_cmd.scan_rd))
        else $error("read data valid without a scan read");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> (r_count <= FULL_CNT))
        else $error("miss count beyond table size");

    a_hit_xor_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> !(res_hit && res_filled))
        else $error("hit and fill in the same step");

endmodule

`default_nettype wire

/* design/detector_pair_sram_table.sv */
// top level of the detector pair table: controller and datapath
`timescale 1ns / 1ps
`default_nettype none

// fully associative table of TABLE_ENTRIES pair addresses with an evictable mark per
// entry. a word on the slave side carries the command in tuser and the detector pair
// in tdata; the pair is ordered smaller-first, mapped to base + (b1 * count + b2 - b1
// - 1) * ELEM_BYTES and looked up by a scan through the entry memory, one entry a
// cycle over its single read port. access, prefetch and fill words pass the three
// address steps, the scan, a drain state and the update; the result is pushed once
// the output register is free and the next word is taken after it. an invalidate
// sweeps the evictable marks, one entry a cycle, then updates and pushes its result.
// after reset a clearing pass sets every entry to address zero and evictable; no word
// is taken during it, configuration writes are. the result sits in an output register
// so the next word is taken while it waits. configuration must be written only while
// the block is idle; the block itself does not enforce it.
module detector_pair_sram_table #(
    parameter int TABLE_ENTRIES = dpst_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // slave side
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // first_detector[15:0], second_detector[31:16], mark_evictable[32], zero pad
    input  wire  [dpst_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // cmd[1:0]
    input  wire  [dpst_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // master side
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // hit[0], pair_address[32:1], slot[38:33], filled[39], table_full[40], zero pad
    output logic [dpst_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // configuration write port
    input  wire                                i_cfg_we,
    input  wire  [dpst_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire  [dpst_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dpst_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencing of each word
    dpst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // address map, entry memories and the result register
    dpst_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status)
    );

endmodule

`default_nettype wire
